### src/tvc_pkg.sv
// ----------------------------------------------------------------------------
// Tone and volume command generator package
// Shared types, register indexes, command codes and the tone step function.
// ----------------------------------------------------------------------------
package tvc_pkg;

   // Configuration register indexes.
   localparam logic CSR_VOLUME_LIMIT = 1'b0;
   localparam logic CSR_TONE_LIMIT   = 1'b1;

   // Reset values of the configuration registers.
   localparam logic [5:0] VOLUME_LIMIT_RESET = 6'd60;
   localparam logic [2:0] TONE_LIMIT_RESET   = 3'd7;

   // Reset value of the attenuation count.
   localparam logic [5:0] VOLUME_RESET = 6'd32;

   // Audio-processor tone codes.
   localparam logic [7:0] TREBLE_FLAT_CODE      = 8'd127;
   localparam logic [7:0] TREBLE_UP_FROM_FLAT   = 8'd126;
   localparam logic [7:0] TREBLE_DOWN_FROM_FLAT = 8'd118;
   localparam logic [7:0] BASS_FLAT_CODE        = 8'd111;
   localparam logic [7:0] BASS_UP_FROM_FLAT     = 8'd110;
   localparam logic [7:0] BASS_DOWN_FROM_FLAT   = 8'd102;

   // Cursor positions.
   typedef enum logic [1:0] {
      SEL_VOLUME = 2'd0,
      SEL_TREBLE = 2'd1,
      SEL_BASS   = 2'd2
   } sel_type;

   // One result transaction.
   typedef struct packed {
      logic              send_valid;
      logic [7:0]        send_byte;
      logic [1:0]        selection;
      logic [5:0]        volume_steps;
      logic signed [3:0] treble_steps;
      logic signed [3:0] bass_steps;
   } rsp_type;

   // Outcome of one tone step.
   typedef struct packed {
      logic signed [3:0] pos;
      logic [7:0]        code;
      logic              changed;
   } tone_type;

   // Steps a treble or bass position by one toward boost (up) or cut.
   // A step past the limit leaves everything as it is.
   function automatic tone_type tone_step(
      input logic signed [3:0] pos,
      input logic [7:0]        code,
      input logic              up,
      input logic [2:0]        lim,
      input logic [7:0]        up_flat,
      input logic [7:0]        down_flat
   );
      tone_type          res;
      logic signed [3:0] lim_pos;
      logic signed [3:0] lim_neg;
      lim_pos = $signed({1'b0, lim});
      lim_neg = -lim_pos;
      res.pos     = pos;
      res.code    = code;
      res.changed = 1'b0;
      if (up) begin
         if (pos < lim_pos) begin
            if (pos > 4'sd0) begin
               res.code = code - 8'd1;
            end else if (pos < 4'sd0) begin
               res.code = code + 8'd1;
            end else begin
               res.code = up_flat;
            end
            res.pos     = pos + 4'sd1;
            res.changed = 1'b1;
         end
      end else begin
         if (pos > lim_neg) begin
            if (pos > 4'sd0) begin
               res.code = code + 8'd1;
            end else if (pos < 4'sd0) begin
               res.code = code - 8'd1;
            end else begin
               res.code = down_flat;
            end
            res.pos     = pos - 4'sd1;
            res.changed = 1'b1;
         end
      end
      return res;
   endfunction

endpackage

### src/tvc_if.sv
// ----------------------------------------------------------------------------
// Tone and volume command generator channels
// Valid/ready channel interfaces for polls, results and register writes.
// ----------------------------------------------------------------------------
interface tvc_req_if;
   logic              valid;
   logic              ready;
   logic signed [1:0] encoder_move;
   logic              button_level;

   modport source (output valid, output encoder_move, output button_level, input ready);
   modport sink   (input valid, input encoder_move, input button_level, output ready);
endinterface

interface tvc_rsp_if;
   logic              valid;
   logic              ready;
   logic              send_valid;
   logic [7:0]        send_byte;
   logic [1:0]        selection;
   logic [5:0]        volume_steps;
   logic signed [3:0] treble_steps;
   logic signed [3:0] bass_steps;

   modport source (output valid, output send_valid, output send_byte, output selection,
                   output volume_steps, output treble_steps, output bass_steps,
                   input ready);
   modport sink   (input valid, input send_valid, input send_byte, input selection,
                   input volume_steps, input treble_steps, input bass_steps,
                   output ready);
endinterface

interface tvc_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [5:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### src/tone_volume_command_generator.sv
// ----------------------------------------------------------------------------
// Tone and volume command generator
// Turns encoder and button polls into volume, treble and bass command bytes.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload
//   req_if    in         encoder_move (2 bit signed), button_level
//   rsp_if    out        send_valid, send_byte, selection, volume_steps,
//                        treble_steps, bass_steps
//   csr_if    in         index (0 volume limit, 1 tone limit), data (6 bit)
//
// Every poll transaction is handled at the accepting edge: the settings, cursor
// and pending flags are updated there and the result lands in the output
// register, so one poll per cycle is sustained while req_if.ready is high.
// A two-entry output buffer (output register plus skid register) lets a poll
// be accepted while one finished result still waits; req_if.ready falls only
// when both entries are full. Reset is synchronous and restores the reset
// settings and limits; register writes are always accepted.
//
module tone_volume_command_generator
   import tvc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   tvc_req_if.sink      req_if,
   tvc_rsp_if.source    rsp_if,
   tvc_csr_if.sink      csr_if
);

   // Configuration registers.
   logic [5:0] volume_limit_ff;
   logic [2:0] tone_limit_ff;

   // Control state.
   sel_type           cursor_ff,          cursor_in;
   logic [5:0]        volume_atten_ff,    volume_atten_in;
   logic signed [3:0] treble_pos_ff,      treble_pos_in;
   logic [7:0]        treble_code_ff,     treble_code_in;
   logic signed [3:0] bass_pos_ff,        bass_pos_in;
   logic [7:0]        bass_code_ff,       bass_code_in;
   logic              volume_pending_ff,  volume_pending_in;
   logic              treble_pending_ff,  treble_pending_in;
   logic              bass_pending_ff,    bass_pending_in;
   logic              button_last_ff,     button_last_in;
   logic              press_seen_ff,      press_seen_in;
   logic              release_seen_ff,    release_seen_in;

   // Output register and skid register.
   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    skid_valid_ff;
   rsp_type skid_data_ff;

   logic    req_take;
   logic    rsp_take;
   rsp_type result;

   logic     step_up;
   logic     step_down;
   tone_type treble_res;
   tone_type bass_res;
   logic     press_tmp;
   logic     release_tmp;
   logic     vol_pend_tmp;
   logic     tre_pend_tmp;
   logic     bas_pend_tmp;

   assign req_if.ready = !skid_valid_ff;
   assign csr_if.ready = 1'b1;
   assign req_take     = req_if.valid && req_if.ready;
   assign rsp_take     = out_valid_ff && rsp_if.ready;

   // Encoder code 1 is up; both negative codes are taken as down.
   assign step_up   = (req_if.encoder_move == 2'sd1);
   assign step_down = req_if.encoder_move[1];

   assign treble_res = tone_step(treble_pos_ff, treble_code_ff, step_up, tone_limit_ff,
                                 TREBLE_UP_FROM_FLAT, TREBLE_DOWN_FROM_FLAT);
   assign bass_res   = tone_step(bass_pos_ff, bass_code_ff, step_up, tone_limit_ff,
                                 BASS_UP_FROM_FLAT, BASS_DOWN_FROM_FLAT);

   // Next state and result of one poll.
   always_comb begin
      volume_atten_in = volume_atten_ff;
      treble_pos_in   = treble_pos_ff;
      treble_code_in  = treble_code_ff;
      bass_pos_in     = bass_pos_ff;
      bass_code_in    = bass_code_ff;
      vol_pend_tmp    = volume_pending_ff;
      tre_pend_tmp    = treble_pending_ff;
      bas_pend_tmp    = bass_pending_ff;

      // The encoder acts on the cursor as it stood before this poll.
      if (step_up || step_down) begin
         unique case (cursor_ff)
            SEL_VOLUME: begin
               if (step_up && (volume_atten_ff != 6'd0)) begin
                  volume_atten_in = volume_atten_ff - 6'd1;
                  vol_pend_tmp    = 1'b1;
               end else if (step_down && (volume_atten_ff < volume_limit_ff)) begin
                  volume_atten_in = volume_atten_ff + 6'd1;
                  vol_pend_tmp    = 1'b1;
               end
            end
            SEL_TREBLE: begin
               treble_pos_in  = treble_res.pos;
               treble_code_in = treble_res.code;
               tre_pend_tmp   = tre_pend_tmp || treble_res.changed;
            end
            SEL_BASS: begin
               bass_pos_in  = bass_res.pos;
               bass_code_in = bass_res.code;
               bas_pend_tmp = bas_pend_tmp || bass_res.changed;
            end
            default: begin
            end
         endcase
      end

      // Button edges; a press and a release, in either order, move the cursor.
      press_tmp   = press_seen_ff   || (req_if.button_level && !button_last_ff);
      release_tmp = release_seen_ff || (!req_if.button_level && button_last_ff);
      cursor_in   = cursor_ff;
      if (press_tmp && release_tmp) begin
         unique case (cursor_ff)
            SEL_VOLUME: cursor_in = SEL_TREBLE;
            SEL_TREBLE: cursor_in = SEL_BASS;
            default:    cursor_in = SEL_VOLUME;
         endcase
         press_seen_in   = 1'b0;
         release_seen_in = 1'b0;
      end else begin
         press_seen_in   = press_tmp;
         release_seen_in = release_tmp;
      end
      button_last_in = req_if.button_level;

      // At most one queued command byte goes out: volume, then treble, then bass.
      result.send_valid   = 1'b0;
      result.send_byte    = 8'd0;
      volume_pending_in   = vol_pend_tmp;
      treble_pending_in   = tre_pend_tmp;
      bass_pending_in     = bas_pend_tmp;
      priority if (vol_pend_tmp) begin
         result.send_valid = 1'b1;
         result.send_byte  = {2'b00, volume_atten_in};
         volume_pending_in = 1'b0;
      end else if (tre_pend_tmp) begin
         result.send_valid = 1'b1;
         result.send_byte  = treble_code_in;
         treble_pending_in = 1'b0;
      end else if (bas_pend_tmp) begin
         result.send_valid = 1'b1;
         result.send_byte  = bass_code_in;
         bass_pending_in   = 1'b0;
      end
      result.selection    = cursor_in;
      result.volume_steps = volume_atten_in;
      result.treble_steps = treble_pos_in;
      result.bass_steps   = bass_pos_in;
   end

   // Configuration registers; a write is accepted in any cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         volume_limit_ff <= VOLUME_LIMIT_RESET;
         tone_limit_ff   <= TONE_LIMIT_RESET;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_VOLUME_LIMIT: volume_limit_ff <= csr_if.data;
            CSR_TONE_LIMIT:   tone_limit_ff   <= csr_if.data[2:0];
            default: begin
            end
         endcase
      end
   end

   // Settings state, updated on every accepted poll.
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff         <= SEL_VOLUME;
         volume_atten_ff   <= VOLUME_RESET;
         treble_pos_ff     <= 4'sd0;
         treble_code_ff    <= TREBLE_FLAT_CODE;
         bass_pos_ff       <= 4'sd0;
         bass_code_ff      <= BASS_FLAT_CODE;
         volume_pending_ff <= 1'b0;
         treble_pending_ff <= 1'b0;
         bass_pending_ff   <= 1'b0;
         button_last_ff    <= 1'b0;
         press_seen_ff     <= 1'b0;
         release_seen_ff   <= 1'b0;
      end else if (req_take) begin
         cursor_ff         <= cursor_in;
         volume_atten_ff   <= volume_atten_in;
         treble_pos_ff     <= treble_pos_in;
         treble_code_ff    <= treble_code_in;
         bass_pos_ff       <= bass_pos_in;
         bass_code_ff      <= bass_code_in;
         volume_pending_ff <= volume_pending_in;
         treble_pending_ff <= treble_pending_in;
         bass_pending_ff   <= bass_pending_in;
         button_last_ff    <= button_last_in;
         press_seen_ff     <= press_seen_in;
         release_seen_ff   <= release_seen_in;
      end
   end

   // Output buffer control. The skid entry fills only when a poll arrives
   // while the output register holds a result that is not being taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (req_take) begin
         if (out_valid_ff && !rsp_take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (rsp_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Output buffer payload.
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_take) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (req_take) begin
         if (out_valid_ff && !rsp_take) begin
            skid_data_ff <= result;
         end else begin
            out_data_ff <= result;
         end
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.send_valid   = out_data_ff.send_valid;
   assign rsp_if.send_byte    = out_data_ff.send_byte;
   assign rsp_if.selection    = out_data_ff.selection;
   assign rsp_if.volume_steps = out_data_ff.volume_steps;
   assign rsp_if.treble_steps = out_data_ff.treble_steps;
   assign rsp_if.bass_steps   = out_data_ff.bass_steps;

endmodule

### sim/tone_volume_command_generator_tb.sv
// ----------------------------------------------------------------------------
// Tone and volume command generator testbench
// Drives control polls and limit register writes into the block, predicts
// every result transaction and compares it field by field, under random
// gaps on the poll side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tone_volume_command_generator_tb;
   import tvc_pkg::*;

   // Encoder directions as they appear on the two-bit signed field.
   localparam logic signed [1:0] MOVE_NONE     = 2'sb00;
   localparam logic signed [1:0] MOVE_UP       = 2'sb01;
   localparam logic signed [1:0] MOVE_DOWN     = 2'sb11;
   localparam logic signed [1:0] MOVE_DOWN_ALT = 2'sb10;

   // Index into the tone state arrays.
   localparam int TONE_TREBLE = 0;
   localparam int TONE_BASS   = 1;

   localparam int DIRECTED_ROWS   = 22;
   localparam int PHASES          = 8;
   localparam int POLLS_PER_PHASE = 206;
   localparam int SETTLE_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT  = 1000;
   localparam int REPORT_LIMIT    = 10;

   // One row of the directed table. Rows with has_want set carry the result
   // that is compared; the others are checked against the predictor.
   typedef struct packed {
      logic signed [1:0] move;
      logic              level;
      logic              has_want;
      rsp_type           want;
   } poll_row_type;

   logic clock;
   logic reset;

   tvc_req_if req_chan ();
   tvc_rsp_if rsp_chan ();
   tvc_csr_if csr_chan ();

   tone_volume_command_generator i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan),
      .csr_if (csr_chan)
   );

   // ------------------------------------------------------------------------
   // Predictor state. This is our own copy of the block's settings, cursor,
   // queued commands and button tracking, plus the two limit registers.
   // ------------------------------------------------------------------------
   logic [5:0]        vol_lim;
   logic [2:0]        tone_lim;
   sel_type           cur_sel;
   logic [5:0]        atten;
   logic signed [3:0] tone_pos [2];
   logic [7:0]        tone_cmd [2];
   logic              tone_queued [2];
   logic              vol_queued;
   logic              btn_prev;
   logic              press_flag;
   logic              release_flag;

   // Results that the block still owes us, oldest first.
   rsp_type expected_results[$];

   // Bookkeeping for the run.
   int  fault_count;
   int  poll_count;
   int  result_count;
   int  byte_count;
   int  write_count;
   int  vol_low, vol_high;
   int  tone_low, tone_high;
   bit  no_gaps;
   logic button_held;

   // ------------------------------------------------------------------------
   // Clock: period of 4 time units.
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Returns an idle length: usually none, sometimes a few cycles, and now
   // and then a long one. During a burst phase every gap is zero.
   function automatic int pick_gap();
      int roll;
      if (no_gaps) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 65) begin
         return 0;
      end
      if (roll < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic rsp_type make_rsp(
      input logic              sv,
      input logic [7:0]        cmd,
      input sel_type           sel,
      input logic [5:0]        vol,
      input logic signed [3:0] treble,
      input logic signed [3:0] bass
   );
      rsp_type r;
      r.send_valid   = sv;
      r.send_byte    = cmd;
      r.selection    = sel;
      r.volume_steps = vol;
      r.treble_steps = treble;
      r.bass_steps   = bass;
      return r;
   endfunction

   function automatic void reset_model();
      vol_lim      = VOLUME_LIMIT_RESET;
      tone_lim     = TONE_LIMIT_RESET;
      cur_sel      = SEL_VOLUME;
      atten        = VOLUME_RESET;
      tone_pos[TONE_TREBLE]    = 4'sd0;
      tone_pos[TONE_BASS]      = 4'sd0;
      tone_cmd[TONE_TREBLE]    = TREBLE_FLAT_CODE;
      tone_cmd[TONE_BASS]      = BASS_FLAT_CODE;
      tone_queued[TONE_TREBLE] = 1'b0;
      tone_queued[TONE_BASS]   = 1'b0;
      vol_queued   = 1'b0;
      btn_prev     = 1'b0;
      press_flag   = 1'b0;
      release_flag = 1'b0;
   endfunction

   // One treble or bass step. A step past the stop changes nothing and
   // queues nothing. Leaving flat jumps to the fixed first boost or cut code;
   // after that each step away from flat lowers the code by one and each step
   // back toward flat raises it by one.
   function automatic void step_tone(input int which, input logic up);
      int         p;
      int         lim;
      logic [7:0] up_flat;
      logic [7:0] down_flat;
      p         = tone_pos[which];
      lim       = tone_lim;
      up_flat   = (which == TONE_TREBLE) ? TREBLE_UP_FROM_FLAT : BASS_UP_FROM_FLAT;
      down_flat = (which == TONE_TREBLE) ? TREBLE_DOWN_FROM_FLAT : BASS_DOWN_FROM_FLAT;
      if (up) begin
         if (p >= lim) begin
            return;
         end
         if (p > 0) begin
            tone_cmd[which] = tone_cmd[which] - 8'd1;
         end else if (p < 0) begin
            tone_cmd[which] = tone_cmd[which] + 8'd1;
         end else begin
            tone_cmd[which] = up_flat;
         end
         tone_pos[which] = 4'(p + 1);
      end else begin
         if (p <= -lim) begin
            return;
         end
         if (p > 0) begin
            tone_cmd[which] = tone_cmd[which] + 8'd1;
         end else if (p < 0) begin
            tone_cmd[which] = tone_cmd[which] - 8'd1;
         end else begin
            tone_cmd[which] = down_flat;
         end
         tone_pos[which] = 4'(p - 1);
      end
      tone_queued[which] = 1'b1;
      if (p + (up ? 1 : -1) < tone_low) tone_low = p + (up ? 1 : -1);
      if (p + (up ? 1 : -1) > tone_high) tone_high = p + (up ? 1 : -1);
   endfunction

   // Works out the result of one poll and advances the predictor state.
   function automatic rsp_type predict_poll(input logic signed [1:0] move, input logic level);
      rsp_type r;
      logic    up;
      logic    stepping;
      up       = (move == MOVE_UP);
      stepping = (move != MOVE_NONE);
      // The encoder acts on the cursor as it stood before this poll's button.
      if (stepping) begin
         case (cur_sel)
            SEL_VOLUME: begin
               if (up && atten > 6'd0) begin
                  atten      = atten - 6'd1;
                  vol_queued = 1'b1;
               end else if (!up && atten < vol_lim) begin
                  atten      = atten + 6'd1;
                  vol_queued = 1'b1;
               end
            end
            SEL_TREBLE: step_tone(TONE_TREBLE, up);
            SEL_BASS:   step_tone(TONE_BASS, up);
            default: ;
         endcase
      end
      if (level != btn_prev) begin
         if (level) begin
            press_flag = 1'b1;
         end else begin
            release_flag = 1'b1;
         end
      end
      if (press_flag && release_flag) begin
         case (cur_sel)
            SEL_VOLUME: cur_sel = SEL_TREBLE;
            SEL_TREBLE: cur_sel = SEL_BASS;
            default:    cur_sel = SEL_VOLUME;
         endcase
         press_flag   = 1'b0;
         release_flag = 1'b0;
      end
      btn_prev = level;
      r = '0;
      if (vol_queued) begin
         r.send_valid = 1'b1;
         r.send_byte  = {2'b00, atten};
         vol_queued   = 1'b0;
      end else if (tone_queued[TONE_TREBLE]) begin
         r.send_valid = 1'b1;
         r.send_byte  = tone_cmd[TONE_TREBLE];
         tone_queued[TONE_TREBLE] = 1'b0;
      end else if (tone_queued[TONE_BASS]) begin
         r.send_valid = 1'b1;
         r.send_byte  = tone_cmd[TONE_BASS];
         tone_queued[TONE_BASS] = 1'b0;
      end
      r.selection    = cur_sel;
      r.volume_steps = atten;
      r.treble_steps = tone_pos[TONE_TREBLE];
      r.bass_steps   = tone_pos[TONE_BASS];
      if (int'(atten) < vol_low) vol_low = atten;
      if (int'(atten) > vol_high) vol_high = atten;
      return r;
   endfunction

   task automatic report_fault(input string msg);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) begin
         $display("[%0t] %s", $time, msg);
      end
   endtask

   // ------------------------------------------------------------------------
   // Poll driver. An optional gap drops valid first; then the transaction is
   // held until the block takes it. On acceptance the expectation is queued.
   // Valid is left high so that back-to-back transactions need only one
   // assignment per edge.
   // ------------------------------------------------------------------------
   task automatic send_poll(
      input logic signed [1:0] move,
      input logic              level,
      input logic              has_want,
      input rsp_type           want
   );
      int      idle;
      rsp_type predicted;
      idle = pick_gap();
      if (idle > 0) begin
         req_chan.valid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.encoder_move <= move;
      req_chan.button_level <= level;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predicted = predict_poll(move, level);
      expected_results.push_back(has_want ? want : predicted);
      poll_count++;
   endtask

   // Writes both limit registers back to back and then drops valid. The tone
   // limit is three bits wide inside a six-bit data field, so random upper
   // bits go along to show that they are ignored.
   task automatic write_limits(input logic [5:0] vol, input logic [2:0] tone);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= CSR_VOLUME_LIMIT;
      csr_chan.data  <= vol;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      vol_lim = vol;
      write_count++;
      csr_chan.index <= CSR_TONE_LIMIT;
      csr_chan.data  <= {3'($urandom_range(0, 7)), tone};
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      tone_lim = tone;
      write_count++;
      csr_chan.valid <= 1'b0;
   endtask

   // Stops sending, waits for every owed result, then lets the pipeline go
   // quiet before anything else touches the block.
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Random polls. Most of the traffic is made of runs of steps in one
   // direction, long enough to drive volume and tone into their stops, each
   // run optionally preceded by a few press-and-release cycles that rotate
   // the cursor. The rest is noise: any encoder value with any button level.
   // ------------------------------------------------------------------------
   task automatic run_random_polls(input int count);
      int                sent;
      int                run_len;
      int                turns;
      int                i;
      logic              up;
      logic signed [1:0] move;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 4) != 0) begin
            turns = $urandom_range(0, 2);
            for (i = 0; i < 2 * turns && sent < count; i++) begin
               button_held = ~button_held;
               send_poll(2'($urandom_range(0, 3)), button_held, 1'b0, '0);
               sent++;
            end
            up      = $urandom_range(0, 1);
            run_len = $urandom_range(1, 48);
            for (i = 0; i < run_len && sent < count; i++) begin
               if (up) begin
                  move = MOVE_UP;
               end else begin
                  move = $urandom_range(0, 1) ? MOVE_DOWN : MOVE_DOWN_ALT;
               end
               if ($urandom_range(0, 9) == 0) begin
                  move = MOVE_NONE;
               end
               send_poll(move, button_held, 1'b0, '0);
               sent++;
            end
         end else begin
            run_len = $urandom_range(1, 8);
            for (i = 0; i < run_len && sent < count; i++) begin
               button_held = $urandom_range(0, 1);
               send_poll(2'($urandom_range(0, 3)), button_held, 1'b0, '0);
               sent++;
            end
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Result side: ready is high with random stalls, most short and a few
   // long, and none at all during a burst phase.
   // ------------------------------------------------------------------------
   initial begin : result_sink
      int hold;
      rsp_chan.ready <= 1'b0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            hold--;
         end else begin
            rsp_chan.ready <= 1'b1;
            hold = pick_gap();
         end
      end
   end

   // Every accepted result is compared with the oldest expectation.
   always @(posedge clock) begin : result_check
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.send_valid   = rsp_chan.send_valid;
         got.send_byte    = rsp_chan.send_byte;
         got.selection    = rsp_chan.selection;
         got.volume_steps = rsp_chan.volume_steps;
         got.treble_steps = rsp_chan.treble_steps;
         got.bass_steps   = rsp_chan.bass_steps;
         result_count++;
         if (expected_results.size() == 0) begin
            report_fault($sformatf("Result with nothing expected: valid=%0b byte=%0d",
                                   got.send_valid, got.send_byte));
         end else begin
            want = expected_results.pop_front();
            if (got.send_valid === 1'b1) begin
               byte_count++;
            end
            if (got.send_valid !== want.send_valid || got.send_byte !== want.send_byte ||
                got.selection !== want.selection || got.volume_steps !== want.volume_steps ||
                got.treble_steps !== want.treble_steps ||
                got.bass_steps !== want.bass_steps) begin
               report_fault($sformatf({"Result %0d mismatch: expected valid=%0b byte=%0d ",
                                       "sel=%0d vol=%0d treble=%0d bass=%0d, got valid=%0b ",
                                       "byte=%0d sel=%0d vol=%0d treble=%0d bass=%0d"},
                                      result_count, want.send_valid, want.send_byte,
                                      want.selection, want.volume_steps, want.treble_steps,
                                      want.bass_steps, got.send_valid, got.send_byte,
                                      got.selection, got.volume_steps, got.treble_steps,
                                      got.bass_steps));
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: too many cycles in a row without any transaction on any
   // channel means the block has hung.
   // ------------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             (csr_chan.valid && csr_chan.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
      $display("tone_volume_command_generator_tb: FAIL");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------------
   initial begin : stimulus
      poll_row_type directed_rows [DIRECTED_ROWS];
      logic [5:0]   phase_vol  [PHASES];
      logic [2:0]   phase_tone [PHASES];
      int           r;
      int           ph;

      fault_count  = 0;
      poll_count   = 0;
      result_count = 0;
      byte_count   = 0;
      write_count  = 0;
      vol_low      = VOLUME_RESET;
      vol_high     = VOLUME_RESET;
      tone_low     = 0;
      tone_high    = 0;
      no_gaps      = 1'b0;
      button_held  = 1'b0;
      reset_model();

      // All block inputs get known values before the first edge.
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.encoder_move <= MOVE_NONE;
      req_chan.button_level <= 1'b0;
      csr_chan.valid        <= 1'b0;
      csr_chan.index        <= CSR_VOLUME_LIMIT;
      csr_chan.data         <= '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table, run with the reset limits (60 and 7). It covers the
      // reset state, all four encoder codes including -2 read as down, the
      // first boost and cut codes out of flat for both tones, a poll where
      // the encoder and the button release land together (the encoder still
      // acts on the old cursor), and a full cursor rotation.
      directed_rows = '{
         '{MOVE_NONE,     1'b0, 1'b1, make_rsp(1'b0, 8'd0, SEL_VOLUME, 6'd32, 4'sd0, 4'sd0)},
         '{MOVE_UP,       1'b0, 1'b1, make_rsp(1'b1, 8'd31, SEL_VOLUME, 6'd31, 4'sd0, 4'sd0)},
         '{MOVE_DOWN,     1'b0, 1'b1, make_rsp(1'b1, 8'd32, SEL_VOLUME, 6'd32, 4'sd0, 4'sd0)},
         '{MOVE_DOWN_ALT, 1'b0, 1'b1, make_rsp(1'b1, 8'd33, SEL_VOLUME, 6'd33, 4'sd0, 4'sd0)},
         '{MOVE_NONE,     1'b1, 1'b1, make_rsp(1'b0, 8'd0, SEL_VOLUME, 6'd33, 4'sd0, 4'sd0)},
         '{MOVE_NONE,     1'b0, 1'b1, make_rsp(1'b0, 8'd0, SEL_TREBLE, 6'd33, 4'sd0, 4'sd0)},
         '{MOVE_UP,       1'b0, 1'b1,
           make_rsp(1'b1, TREBLE_UP_FROM_FLAT, SEL_TREBLE, 6'd33, 4'sd1, 4'sd0)},
         '{MOVE_UP,       1'b0, 1'b0, '0},
         '{MOVE_DOWN,     1'b0, 1'b0, '0},
         '{MOVE_DOWN,     1'b0, 1'b0, '0},
         '{MOVE_DOWN,     1'b0, 1'b1,
           make_rsp(1'b1, TREBLE_DOWN_FROM_FLAT, SEL_TREBLE, 6'd33, -4'sd1, 4'sd0)},
         '{MOVE_DOWN_ALT, 1'b0, 1'b0, '0},
         '{MOVE_UP,       1'b1, 1'b0, '0},
         '{MOVE_UP,       1'b0, 1'b0, '0},
         '{MOVE_UP,       1'b0, 1'b1,
           make_rsp(1'b1, BASS_UP_FROM_FLAT, SEL_BASS, 6'd33, 4'sd0, 4'sd1)},
         '{MOVE_DOWN,     1'b0, 1'b0, '0},
         '{MOVE_DOWN,     1'b0, 1'b1,
           make_rsp(1'b1, BASS_DOWN_FROM_FLAT, SEL_BASS, 6'd33, 4'sd0, -4'sd1)},
         '{MOVE_NONE,     1'b1, 1'b0, '0},
         '{MOVE_NONE,     1'b1, 1'b0, '0},
         '{MOVE_DOWN,     1'b0, 1'b0, '0},
         '{MOVE_UP,       1'b0, 1'b0, '0},
         '{MOVE_NONE,     1'b0, 1'b0, '0}
      };
      for (r = 0; r < DIRECTED_ROWS; r++) begin
         send_poll(directed_rows[r].move, directed_rows[r].level,
                   directed_rows[r].has_want, directed_rows[r].want);
      end
      settle();

      // Limit settings per phase. The order matters: a phase with the
      // widest range lets the settings wander far out, and the next phase
      // pulls the limits in below them, so only steps back toward the range
      // are taken. Zero limits hold the tones at flat and volume at 0 dB once there.
      phase_vol  = '{6'd60, 6'd63, 6'd10, 6'd0, 6'd63, 6'd1, 6'd0, 6'd0};
      phase_tone = '{3'd7,  3'd7,  3'd2,  3'd0, 3'd1,  3'd7, 3'd0, 3'd0};
      phase_vol[6]  = 6'($urandom_range(0, 63));
      phase_tone[6] = 3'($urandom_range(0, 7));
      phase_vol[7]  = 6'($urandom_range(0, 63));
      phase_tone[7] = 3'($urandom_range(0, 7));

      for (ph = 0; ph < PHASES; ph++) begin
         write_limits(phase_vol[ph], phase_tone[ph]);
         // Some phases run with no gaps on either side at all.
         no_gaps = ($urandom_range(0, 3) == 0);
         run_random_polls(POLLS_PER_PHASE);
         settle();
      end

      if (expected_results.size() != 0) begin
         report_fault($sformatf("%0d results never arrived", expected_results.size()));
      end

      $display("Run summary: %0d polls, %0d results checked, %0d command bytes, %0d writes.",
               poll_count, result_count, byte_count, write_count);
      $display("Volume covered %0d to %0d steps, tones %0d to %0d steps; %0d faults.",
               vol_low, vol_high, tone_low, tone_high, fault_count);
      if (fault_count == 0) begin
         $display("tone_volume_command_generator_tb: PASS");
      end else begin
         $display("tone_volume_command_generator_tb: FAIL");
      end
      $finish;
   end

endmodule
